### rtl/core/chip8_interpreter_core_macros.svh
// Assertion helpers for the core RTL.
// All of them sample on clk and are switched off while rst_n is low.
`ifndef CHIP8_INTERPRETER_CORE_MACROS_SVH
`define CHIP8_INTERPRETER_CORE_MACROS_SVH

// The condition holds on every cycle.
`define C8I_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define C8I_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define C8I_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/c8i_pkg.sv
package c8i_pkg;

    localparam int MEMORY_BYTES  = 4096;
    localparam int MEM_AW        = $clog2(MEMORY_BYTES);
    localparam int STACK_DEPTH   = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_PIXELS = 2048;
    localparam int ROW_COUNT     = SCREEN_PIXELS / SCREEN_WIDTH;
    localparam int COL_AW        = $clog2(SCREEN_WIDTH);
    localparam int ROW_AW        = $clog2(ROW_COUNT);
    localparam int KEY_COUNT     = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QP_W          = $clog2(QUEUE_DEPTH);

    localparam logic [11:0] PC_RESET = 12'h200;

    // request codes on the req_type port
    localparam logic [1:0] REQ_CODE_LOAD  = 2'd0;
    localparam logic [1:0] REQ_CODE_KEY   = 2'd1;
    localparam logic [1:0] REQ_CODE_CYCLE = 2'd2;
    localparam logic [1:0] REQ_CODE_PIXEL = 2'd3;

    // opcode groups (top nibble)
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] FN_GETDT = 8'h07;
    localparam logic [7:0] FN_WKEY  = 8'h0A;
    localparam logic [7:0] FN_SETDT = 8'h15;
    localparam logic [7:0] FN_SETST = 8'h18;
    localparam logic [7:0] FN_ADDI  = 8'h1E;
    localparam logic [7:0] FN_FONT  = 8'h29;
    localparam logic [7:0] FN_BCD   = 8'h33;
    localparam logic [7:0] FN_STORE = 8'h55;
    localparam logic [7:0] FN_LOAD  = 8'h65;

    localparam logic [3:0] VF_INDEX = 4'hF;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_KEY,
        KIND_CYCLE,
        KIND_PIXEL
    } req_kind_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [11:0] address;
        logic [7:0]  load_byte;
        logic [3:0]  key_index;
        logic        key_down;
        logic [7:0]  random_byte;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } q_ctrl_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PIX,
        ST_F_LO,
        ST_RD_X,
        ST_RD_Y,
        ST_EXEC,
        ST_VF,
        ST_BCD1,
        ST_BCD2,
        ST_STORE_RD,
        ST_STORE_WR,
        ST_LOADR_RD,
        ST_LOADR_WR,
        ST_DRAW_RD,
        ST_DRAW_WR,
        ST_FINISH
    } back_state_t;

endpackage

### rtl/core/chip8_interpreter_core.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | req_type, address, load_byte, key_index, key_down, random_byte
// out     | out_valid / out_ready| pixel_value, program_counter, drew_sprite, sound_active,
//         |                      | waiting_for_key, unknown_opcode
//
// Load and key requests go straight from idle to finish; pixel reads pass a frame-read state;
// instructions fetch, read VX and VY, then execute. DXYN adds a read and a write per sprite row,
// FX55/FX65 a read and a write per register, FX33 its digit writes; each store has one read port.
// After reset a pass clears main memory; in_ready stays low meanwhile.
// A two-entry request queue lets the input side run ahead while a result is stalled.
module chip8_interpreter_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] address,
    input  logic [7:0]  load_byte,
    input  logic [3:0]  key_index,
    input  logic        key_down,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        pixel_value,
    output logic [11:0] program_counter,
    output logic        drew_sprite,
    output logic        sound_active,
    output logic        waiting_for_key,
    output logic        unknown_opcode
);

    c8i_pkg::q_head_t head;
    c8i_pkg::q_ctrl_t ctrl;

    c8i_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .address     (address),
        .load_byte   (load_byte),
        .key_index   (key_index),
        .key_down    (key_down),
        .random_byte (random_byte),
        .ctrl        (ctrl),
        .head        (head)
    );

    c8i_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .ctrl            (ctrl),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_value     (pixel_value),
        .program_counter (program_counter),
        .drew_sprite     (drew_sprite),
        .sound_active    (sound_active),
        .waiting_for_key (waiting_for_key),
        .unknown_opcode  (unknown_opcode)
    );

endmodule

### rtl/core/c8i_front.sv
module c8i_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [11:0]       address,
    input  logic [7:0]        load_byte,
    input  logic [3:0]        key_index,
    input  logic              key_down,
    input  logic [7:0]        random_byte,
    input  c8i_pkg::q_ctrl_t  ctrl,
    output c8i_pkg::q_head_t  head
);

    c8i_pkg::item_t            q_mem [c8i_pkg::QUEUE_DEPTH];
    logic [c8i_pkg::QP_W-1:0]  wp_reg;
    logic [c8i_pkg::QP_W-1:0]  rp_reg;
    logic [c8i_pkg::QP_W:0]    cnt_reg;
    c8i_pkg::item_t            item_in;
    logic                      push;
    logic                      pop;

    always_comb
    begin
        item_in.address     = address;
        item_in.load_byte   = load_byte;
        item_in.key_index   = key_index;
        item_in.key_down    = key_down;
        item_in.random_byte = random_byte;
        case (req_type)
            c8i_pkg::REQ_CODE_LOAD:  item_in.kind = c8i_pkg::KIND_LOAD;
            c8i_pkg::REQ_CODE_KEY:   item_in.kind = c8i_pkg::KIND_KEY;
            c8i_pkg::REQ_CODE_CYCLE: item_in.kind = c8i_pkg::KIND_CYCLE;
            c8i_pkg::REQ_CODE_PIXEL: item_in.kind = c8i_pkg::KIND_PIXEL;
            default:                 item_in.kind = c8i_pkg::KIND_PIXEL;
        endcase
    end

    assign in_ready   = (cnt_reg != (c8i_pkg::QP_W+1)'(c8i_pkg::QUEUE_DEPTH)) && !ctrl.clearing;
    assign push       = in_valid && in_ready;
    assign pop        = ctrl.pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.item  = q_mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wp_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/c8i_back.sv
`include "chip8_interpreter_core_macros.svh"

module c8i_back (
    input  logic              clk,
    input  logic              rst_n,
    input  c8i_pkg::q_head_t  head,
    output c8i_pkg::q_ctrl_t  ctrl,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pixel_value,
    output logic [11:0]       program_counter,
    output logic              drew_sprite,
    output logic              sound_active,
    output logic              waiting_for_key,
    output logic              unknown_opcode
);

    localparam int MAW = c8i_pkg::MEM_AW;
    localparam int RAW = c8i_pkg::ROW_AW;
    localparam int CAW = c8i_pkg::COL_AW;
    localparam int SW  = c8i_pkg::SCREEN_WIDTH;

    // storage
    logic [7:0]     mem [c8i_pkg::MEMORY_BYTES];
    logic [7:0]     rf [16];
    logic [SW-1:0]  frame [c8i_pkg::ROW_COUNT];
    logic [11:0]    stk_reg [c8i_pkg::STACK_DEPTH];
    logic [15:0]    rf_vld_reg;
    logic [c8i_pkg::ROW_COUNT-1:0] fr_vld_reg;

    logic [7:0]     mem_q_reg;
    logic [7:0]     rf_q_reg;
    logic           rf_qv_reg;
    logic [SW-1:0]  fr_q_reg;
    logic           fr_qv_reg;

    // memory ports
    logic           mem_we;
    logic [MAW-1:0] mem_wa;
    logic [7:0]     mem_wd;
    logic [MAW-1:0] mem_ra;
    logic           rf_we;
    logic [3:0]     rf_wa;
    logic [7:0]     rf_wd;
    logic [3:0]     rf_ra;
    logic           fr_we;
    logic [RAW-1:0] fr_wa;
    logic [SW-1:0]  fr_wd;
    logic [RAW-1:0] fr_ra;
    logic           fr_clear;
    logic           stk_we;
    logic           out_load;
    logic           pop;

    c8i_pkg::back_state_t state_reg, state_next;
    c8i_pkg::item_t       cur_reg, cur_next;
    logic [11:0]    pc_reg, pc_next;
    logic [15:0]    idx_reg, idx_next;
    logic [c8i_pkg::SP_W-1:0] sp_reg, sp_next;
    logic [7:0]     delay_reg, delay_next;
    logic [7:0]     sound_reg, sound_next;
    logic [15:0]    keys_reg, keys_next;
    logic [7:0]     hi_reg, hi_next;
    logic [15:0]    op_reg, op_next;
    logic [7:0]     vx_reg, vx_next;
    logic [7:0]     vy_reg, vy_next;
    logic [7:0]     vf_reg, vf_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [MAW-1:0] clr_reg, clr_next;
    logic           drew_reg, drew_next;
    logic           wait_reg, wait_next;
    logic           unk_reg, unk_next;
    logic           pix_reg, pix_next;
    logic           hit_reg, hit_next;
    logic           ov_reg, ov_next;

    logic [7:0]     rf_val;
    logic [3:0]     x_f;
    logic [7:0]     nn_f;
    logic [11:0]    pc_p2;
    logic [11:0]    pc_p4;
    logic [8:0]     sum9;
    logic [7:0]     bcd_h;
    logic [7:0]     bcd_rem;
    logic [14:0]    bcd_prod;
    logic [7:0]     bcd_t;
    logic [7:0]     bcd_o;
    logic [15:0]    idx_k;
    logic [SW-1:0]  old_row;
    logic [SW-1:0]  mask;
    logic [RAW-1:0] draw_row;
    logic [SP_DUMMY_W-1:0] unused_w;
    localparam int SP_DUMMY_W = 1;
    logic [c8i_pkg::SP_W-1:0] sp_dec;
    logic           key_found;
    logic [3:0]     key_first;
    logic [7:0]     sound_after;

    assign unused_w = 1'b0;
    assign rf_val   = rf_qv_reg ? rf_q_reg : 8'h00;
    assign x_f      = op_reg[11:8];
    assign nn_f     = op_reg[7:0];
    assign pc_p2    = pc_reg + 12'd2;
    assign pc_p4    = pc_reg + 12'd4;
    assign sum9     = {1'b0, vx_reg} + {1'b0, rf_val};
    assign idx_k    = idx_reg + {12'd0, cnt_reg};
    assign sp_dec   = sp_reg - 1'b1;
    assign draw_row = RAW'(vy_reg + {4'd0, cnt_reg});
    assign old_row  = fr_qv_reg ? fr_q_reg : '0;

    // decimal digits of VX without a divider
    always_comb
    begin
        if (vx_reg >= 8'd200)
        begin
            bcd_h = 8'd2;
        end
        else if (vx_reg >= 8'd100)
        begin
            bcd_h = 8'd1;
        end
        else
        begin
            bcd_h = 8'd0;
        end
        bcd_rem  = vx_reg - 8'(bcd_h * 8'd100);
        bcd_prod = 15'(bcd_rem) * 15'd205;
        bcd_t    = 8'(bcd_prod >> 11);
        bcd_o    = bcd_rem - 8'(bcd_t * 8'd10);
    end

    always_comb
    begin
        mask = '0;
        for (int c = 0; c < 8; c++)
        begin
            if (mem_q_reg[7 - c])
            begin
                mask[CAW'(vx_reg[CAW-1:0] + CAW'(c))] = 1'b1;
            end
        end
    end

    // lowest pressed key
    always_comb
    begin
        key_found = 1'b0;
        key_first = '0;
        for (int k = c8i_pkg::KEY_COUNT - 1; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                key_found = 1'b1;
                key_first = 4'(k);
            end
        end
    end

    assign sound_after = (cur_reg.kind == c8i_pkg::KIND_CYCLE && sound_reg != 8'd0)
                         ? sound_reg - 8'd1 : sound_reg;

    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        delay_next = delay_reg;
        sound_next = sound_reg;
        keys_next  = keys_reg;
        hi_next    = hi_reg;
        op_next    = op_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        vf_next    = vf_reg;
        cnt_next   = cnt_reg;
        clr_next   = clr_reg;
        drew_next  = drew_reg;
        wait_next  = wait_reg;
        unk_next   = unk_reg;
        pix_next   = pix_reg;
        hit_next   = hit_reg;
        mem_we     = 1'b0;
        mem_wa     = clr_reg;
        mem_wd     = 8'h00;
        mem_ra     = pc_reg[MAW-1:0];
        rf_we      = 1'b0;
        rf_wa      = x_f;
        rf_wd      = 8'h00;
        rf_ra      = x_f;
        fr_we      = 1'b0;
        fr_wa      = draw_row;
        fr_wd      = old_row ^ mask;
        fr_ra      = head.item.address[CAW +: RAW];
        fr_clear   = 1'b0;
        stk_we     = 1'b0;
        out_load   = 1'b0;
        pop        = 1'b0;

        case (state_reg)
            c8i_pkg::ST_CLEAR:
            begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = c8i_pkg::ST_IDLE;
                end
            end
            c8i_pkg::ST_IDLE:
            begin
                if (head.valid)
                begin
                    pop       = 1'b1;
                    cur_next  = head.item;
                    drew_next = 1'b0;
                    wait_next = 1'b0;
                    unk_next  = 1'b0;
                    pix_next  = 1'b0;
                    case (head.item.kind)
                        c8i_pkg::KIND_LOAD:
                        begin
                            mem_we     = 1'b1;
                            mem_wa     = head.item.address[MAW-1:0];
                            mem_wd     = head.item.load_byte;
                            state_next = c8i_pkg::ST_FINISH;
                        end
                        c8i_pkg::KIND_KEY:
                        begin
                            keys_next[head.item.key_index] = head.item.key_down;
                            state_next = c8i_pkg::ST_FINISH;
                        end
                        c8i_pkg::KIND_CYCLE:
                        begin
                            state_next = c8i_pkg::ST_F_LO;
                        end
                        default:
                        begin
                            state_next = c8i_pkg::ST_PIX;
                        end
                    endcase
                end
            end
            c8i_pkg::ST_PIX:
            begin
                pix_next   = (cur_reg.address < 12'(c8i_pkg::SCREEN_PIXELS))
                             && fr_q_reg[cur_reg.address[CAW-1:0]] && fr_qv_reg;
                state_next = c8i_pkg::ST_FINISH;
            end
            c8i_pkg::ST_F_LO:
            begin
                hi_next    = mem_q_reg;
                mem_ra     = MAW'(pc_reg + 12'd1);
                state_next = c8i_pkg::ST_RD_X;
            end
            c8i_pkg::ST_RD_X:
            begin
                op_next    = {hi_reg, mem_q_reg};
                rf_ra      = hi_reg[3:0];
                state_next = c8i_pkg::ST_RD_Y;
            end
            c8i_pkg::ST_RD_Y:
            begin
                vx_next    = rf_val;
                // BNNN needs V0 rather than VY
                rf_ra      = (op_reg[15:12] == c8i_pkg::OP_JPV0) ? 4'h0 : op_reg[7:4];
                state_next = c8i_pkg::ST_EXEC;
            end
            c8i_pkg::ST_EXEC:
            begin
                vy_next    = rf_val;
                state_next = c8i_pkg::ST_FINISH;
                case (op_reg[15:12])
                    c8i_pkg::OP_SYS:
                    begin
                        if (op_reg == c8i_pkg::OP_CLS)
                        begin
                            fr_clear  = 1'b1;
                            drew_next = 1'b1;
                            pc_next   = pc_p2;
                        end
                        else if (op_reg == c8i_pkg::OP_RET)
                        begin
                            sp_next = sp_dec;
                            pc_next = stk_reg[sp_dec] + 12'd2;
                        end
                        else
                        begin
                            pc_next = op_reg[11:0];
                        end
                    end
                    c8i_pkg::OP_JP:
                    begin
                        pc_next = op_reg[11:0];
                    end
                    c8i_pkg::OP_CALL:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                        pc_next = op_reg[11:0];
                    end
                    c8i_pkg::OP_SEI:
                    begin
                        pc_next = (vx_reg == nn_f) ? pc_p4 : pc_p2;
                    end
                    c8i_pkg::OP_SNEI:
                    begin
                        pc_next = (vx_reg != nn_f) ? pc_p4 : pc_p2;
                    end
                    c8i_pkg::OP_SER:
                    begin
                        pc_next = (vx_reg == rf_val) ? pc_p4 : pc_p2;
                    end
                    c8i_pkg::OP_LDI:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = nn_f;
                        pc_next = pc_p2;
                    end
                    c8i_pkg::OP_ADDI:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = vx_reg + nn_f;
                        pc_next = pc_p2;
                    end
                    c8i_pkg::OP_ALU:
                    begin
                        pc_next = pc_p2;
                        rf_we   = 1'b1;
                        case (op_reg[3:0])
                            c8i_pkg::ALU_MOV: rf_wd = rf_val;
                            c8i_pkg::ALU_OR:  rf_wd = vx_reg | rf_val;
                            c8i_pkg::ALU_AND: rf_wd = vx_reg & rf_val;
                            c8i_pkg::ALU_XOR: rf_wd = vx_reg ^ rf_val;
                            c8i_pkg::ALU_ADD:
                            begin
                                rf_wd      = sum9[7:0];
                                vf_next    = {7'd0, sum9[8]};
                                state_next = c8i_pkg::ST_VF;
                            end
                            c8i_pkg::ALU_SUB:
                            begin
                                rf_wd      = vx_reg - rf_val;
                                vf_next    = {7'd0, vx_reg > rf_val};
                                state_next = c8i_pkg::ST_VF;
                            end
                            c8i_pkg::ALU_SHR:
                            begin
                                rf_wd      = {1'b0, vx_reg[7:1]};
                                vf_next    = {7'd0, vx_reg[0]};
                                state_next = c8i_pkg::ST_VF;
                            end
                            c8i_pkg::ALU_SBN:
                            begin
                                rf_wd      = rf_val - vx_reg;
                                vf_next    = {7'd0, rf_val > vx_reg};
                                state_next = c8i_pkg::ST_VF;
                            end
                            c8i_pkg::ALU_SHL:
                            begin
                                rf_wd      = {vx_reg[6:0], 1'b0};
                                vf_next    = {7'd0, vx_reg[7]};
                                state_next = c8i_pkg::ST_VF;
                            end
                            default:
                            begin
                                rf_we    = 1'b0;
                                unk_next = 1'b1;
                                pc_next  = pc_reg;
                            end
                        endcase
                    end
                    c8i_pkg::OP_SNER:
                    begin
                        if (op_reg[3:0] != 4'h0)
                        begin
                            unk_next = 1'b1;
                        end
                        else
                        begin
                            pc_next = (vx_reg != rf_val) ? pc_p4 : pc_p2;
                        end
                    end
                    c8i_pkg::OP_LDIDX:
                    begin
                        idx_next = {4'd0, op_reg[11:0]};
                        pc_next  = pc_p2;
                    end
                    c8i_pkg::OP_JPV0:
                    begin
                        pc_next = op_reg[11:0] + {4'd0, rf_val};
                    end
                    c8i_pkg::OP_RND:
                    begin
                        rf_we   = 1'b1;
                        rf_wd   = nn_f & cur_reg.random_byte;
                        pc_next = pc_p2;
                    end
                    c8i_pkg::OP_DRW:
                    begin
                        drew_next  = 1'b1;
                        pc_next    = pc_p2;
                        cnt_next   = '0;
                        hit_next   = 1'b0;
                        state_next = c8i_pkg::ST_DRAW_RD;
                    end
                    c8i_pkg::OP_KEY:
                    begin
                        if (nn_f == c8i_pkg::KEY_SKP)
                        begin
                            pc_next = keys_reg[vx_reg[3:0]] ? pc_p4 : pc_p2;
                        end
                        else if (nn_f == c8i_pkg::KEY_SKNP)
                        begin
                            pc_next = !keys_reg[vx_reg[3:0]] ? pc_p4 : pc_p2;
                        end
                        else
                        begin
                            unk_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_p2;
                        case (nn_f)
                            c8i_pkg::FN_GETDT:
                            begin
                                rf_we = 1'b1;
                                rf_wd = delay_reg;
                            end
                            c8i_pkg::FN_WKEY:
                            begin
                                if (key_found)
                                begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'd0, key_first};
                                end
                                else
                                begin
                                    wait_next = 1'b1;
                                    pc_next   = pc_reg;
                                end
                            end
                            c8i_pkg::FN_SETDT: delay_next = vx_reg;
                            c8i_pkg::FN_SETST: sound_next = vx_reg;
                            c8i_pkg::FN_ADDI:  idx_next = idx_reg + {8'd0, vx_reg};
                            c8i_pkg::FN_FONT:  idx_next = {6'd0, vx_reg, 2'b00} + {8'd0, vx_reg};
                            c8i_pkg::FN_BCD:
                            begin
                                mem_we     = 1'b1;
                                mem_wa     = idx_reg[MAW-1:0];
                                mem_wd     = bcd_h;
                                state_next = c8i_pkg::ST_BCD1;
                            end
                            c8i_pkg::FN_STORE:
                            begin
                                cnt_next   = '0;
                                state_next = c8i_pkg::ST_STORE_RD;
                            end
                            c8i_pkg::FN_LOAD:
                            begin
                                cnt_next   = '0;
                                state_next = c8i_pkg::ST_LOADR_RD;
                            end
                            default:
                            begin
                                unk_next = 1'b1;
                                pc_next  = pc_reg;
                            end
                        endcase
                    end
                endcase
            end
            c8i_pkg::ST_VF:
            begin
                rf_we      = 1'b1;
                rf_wa      = c8i_pkg::VF_INDEX;
                rf_wd      = vf_reg;
                state_next = c8i_pkg::ST_FINISH;
            end
            c8i_pkg::ST_BCD1:
            begin
                mem_we     = 1'b1;
                mem_wa     = MAW'(idx_reg + 16'd1);
                mem_wd     = bcd_t;
                state_next = c8i_pkg::ST_BCD2;
            end
            c8i_pkg::ST_BCD2:
            begin
                mem_we     = 1'b1;
                mem_wa     = MAW'(idx_reg + 16'd2);
                mem_wd     = bcd_o;
                state_next = c8i_pkg::ST_FINISH;
            end
            c8i_pkg::ST_STORE_RD:
            begin
                rf_ra      = cnt_reg;
                state_next = c8i_pkg::ST_STORE_WR;
            end
            c8i_pkg::ST_STORE_WR:
            begin
                mem_we = 1'b1;
                mem_wa = idx_k[MAW-1:0];
                mem_wd = rf_val;
                if (cnt_reg == x_f)
                begin
                    state_next = c8i_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = c8i_pkg::ST_STORE_RD;
                end
            end
            c8i_pkg::ST_LOADR_RD:
            begin
                mem_ra     = idx_k[MAW-1:0];
                state_next = c8i_pkg::ST_LOADR_WR;
            end
            c8i_pkg::ST_LOADR_WR:
            begin
                rf_we = 1'b1;
                rf_wa = cnt_reg;
                rf_wd = mem_q_reg;
                if (cnt_reg == x_f)
                begin
                    state_next = c8i_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = c8i_pkg::ST_LOADR_RD;
                end
            end
            c8i_pkg::ST_DRAW_RD:
            begin
                if (cnt_reg == op_reg[3:0])
                begin
                    vf_next    = {7'd0, hit_reg};
                    state_next = c8i_pkg::ST_VF;
                end
                else
                begin
                    mem_ra     = idx_k[MAW-1:0];
                    fr_ra      = draw_row;
                    state_next = c8i_pkg::ST_DRAW_WR;
                end
            end
            c8i_pkg::ST_DRAW_WR:
            begin
                fr_we      = 1'b1;
                hit_next   = hit_reg | (|(old_row & mask));
                cnt_next   = cnt_reg + 1'b1;
                state_next = c8i_pkg::ST_DRAW_RD;
            end
            c8i_pkg::ST_FINISH:
            begin
                if (!ov_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    sound_next = sound_after;
                    if (cur_reg.kind == c8i_pkg::KIND_CYCLE && delay_reg != 8'd0)
                    begin
                        delay_next = delay_reg - 8'd1;
                    end
                    state_next = c8i_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = c8i_pkg::ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    assign ctrl.pop      = pop;
    assign ctrl.clearing = (state_reg == c8i_pkg::ST_CLEAR);

    // main memory, register file and frame rows: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q_reg <= mem[mem_ra];
        if (rf_we)
        begin
            rf[rf_wa] <= rf_wd;
        end
        rf_q_reg <= rf[rf_ra];
        if (fr_we)
        begin
            frame[fr_wa] <= fr_wd;
        end
        fr_q_reg <= frame[fr_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg <= '0;
            fr_vld_reg <= '0;
            rf_qv_reg  <= 1'b0;
            fr_qv_reg  <= 1'b0;
            for (int i = 0; i < c8i_pkg::STACK_DEPTH; i++)
            begin
                stk_reg[i] <= '0;
            end
        end
        else
        begin
            rf_qv_reg <= rf_vld_reg[rf_ra];
            fr_qv_reg <= fr_vld_reg[fr_ra];
            if (rf_we)
            begin
                rf_vld_reg[rf_wa] <= 1'b1;
            end
            if (fr_clear)
            begin
                fr_vld_reg <= '0;
            end
            else if (fr_we)
            begin
                fr_vld_reg[fr_wa] <= 1'b1;
            end
            if (stk_we)
            begin
                stk_reg[sp_reg] <= pc_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= c8i_pkg::ST_CLEAR;
            pc_reg    <= c8i_pkg::PC_RESET;
            idx_reg   <= '0;
            sp_reg    <= '0;
            delay_reg <= '0;
            sound_reg <= '0;
            keys_reg  <= '0;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            delay_reg <= delay_next;
            sound_reg <= sound_next;
            keys_reg  <= keys_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        hi_reg   <= hi_next;
        op_reg   <= op_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        vf_reg   <= vf_next;
        drew_reg <= drew_next;
        wait_reg <= wait_next;
        unk_reg  <= unk_next;
        pix_reg  <= pix_next;
        hit_reg  <= hit_next;
        if (out_load)
        begin
            pixel_value     <= pix_reg;
            program_counter <= pc_reg;
            drew_sprite     <= drew_reg;
            sound_active    <= |sound_after;
            waiting_for_key <= wait_reg;
            unknown_opcode  <= unk_reg;
        end
    end

    assign out_valid = ov_reg;

    `C8I_ASSERT_IMPLIES(a_no_pop_in_clear, state_reg == c8i_pkg::ST_CLEAR, !ctrl.pop, "request taken during memory clear")
    `C8I_ASSERT_NEXT(a_flag_then_finish, state_reg == c8i_pkg::ST_VF, state_reg == c8i_pkg::ST_FINISH, "flag write not followed by finish")
    `C8I_ASSERT_IMPLIES(a_draw_row_bound, state_reg == c8i_pkg::ST_DRAW_WR, cnt_reg < op_reg[3:0], "sprite row beyond height")
    `C8I_ASSERT_IMPLIES(a_load_only_finish, out_load, state_reg == c8i_pkg::ST_FINISH && unused_w == 1'b0, "result loaded outside finish")

endmodule

### tb/sv/chip8_core_checker.sv
module chip8_core_checker
    import c8i_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [11:0] address,
    input  logic [7:0]  load_byte,
    input  logic [3:0]  key_index,
    input  logic        key_down,
    input  logic [7:0]  random_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        pixel_value,
    input  logic [11:0] program_counter,
    input  logic        drew_sprite,
    input  logic        sound_active,
    input  logic        waiting_for_key,
    input  logic        unknown_opcode,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        pix;
        logic [11:0] pc;
        logic        drew;
        logic        snd;
        logic        wait_key;
        logic        unk;
    } status_t;

    logic [7:0]  mem_m [MEMORY_BYTES];
    logic [7:0]  v_m [16];
    logic [15:0] i_m;
    logic [11:0] pc_m;
    logic [11:0] stk_m [STACK_DEPTH];
    logic [SP_W-1:0] sp_m;
    logic [7:0]  dt_m, st_m;
    logic        fb_m [SCREEN_PIXELS];
    logic        keys_m [KEY_COUNT];
    status_t     expected_status [$];

    function automatic logic [7:0] rd(int unsigned a);
        return mem_m[a % MEMORY_BYTES];
    endfunction

    task automatic wr(int unsigned a, logic [7:0] b);
        mem_m[a % MEMORY_BYTES] = b;
    endtask

    task automatic execute_instr(input logic [7:0] rnd, output logic drew, output logic wk,
                                 output logic unk);
        logic [15:0] op;
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, line;
        logic [11:0] nnn, pc, nxt, skip;
        logic [8:0]  sum;
        logic        hit;
        int          k, r, c, px, py, at;
        op = {rd(pc_m), rd(pc_m + 1)};
        x = op[11:8]; y = op[7:4]; n = op[3:0]; nn = op[7:0]; nnn = op[11:0];
        vx = v_m[x]; vy = v_m[y];
        pc = pc_m; nxt = pc_m + 12'd2; skip = pc_m + 12'd4;
        drew = 0; wk = 0; unk = 0;
        case (op[15:12])
            OP_SYS:
                if (op == OP_CLS) begin
                    foreach (fb_m[j]) fb_m[j] = 0;
                    drew = 1; pc = nxt;
                end
                else if (op == OP_RET) begin
                    sp_m = sp_m - 1'b1;
                    pc = stk_m[sp_m] + 12'd2;
                end
                else pc = nnn;
            OP_JP: pc = nnn;
            OP_CALL:
            begin
                stk_m[sp_m] = pc; sp_m = sp_m + 1'b1; pc = nnn;
            end
            OP_SEI: pc = (vx == nn) ? skip : nxt;
            OP_SNEI: pc = (vx != nn) ? skip : nxt;
            OP_SER: pc = (vx == vy) ? skip : nxt;
            OP_LDI: begin v_m[x] = nn; pc = nxt; end
            OP_ADDI: begin v_m[x] = vx + nn; pc = nxt; end
            OP_ALU:
            begin
                pc = nxt;
                case (n)
                    ALU_MOV: v_m[x] = vy;
                    ALU_OR:  v_m[x] = vx | vy;
                    ALU_AND: v_m[x] = vx & vy;
                    ALU_XOR: v_m[x] = vx ^ vy;
                    ALU_ADD: begin sum = vx + vy; v_m[x] = sum[7:0]; v_m[VF_INDEX] = sum[8]; end
                    ALU_SUB: begin v_m[x] = vx - vy; v_m[VF_INDEX] = vx > vy; end
                    ALU_SHR: begin v_m[x] = vx >> 1; v_m[VF_INDEX] = vx[0]; end
                    ALU_SBN: begin v_m[x] = vy - vx; v_m[VF_INDEX] = vy > vx; end
                    ALU_SHL: begin v_m[x] = vx << 1; v_m[VF_INDEX] = vx[7]; end
                    default: begin unk = 1; pc = pc_m; end
                endcase
            end
            OP_SNER:
                if (n != 0) unk = 1;
                else pc = (vx != vy) ? skip : nxt;
            OP_LDIDX: begin i_m = nnn; pc = nxt; end
            OP_JPV0: pc = nnn + v_m[0];
            OP_RND: begin v_m[x] = nn & rnd; pc = nxt; end
            OP_DRW:
            begin
                hit = 0;
                for (r = 0; r < n; r++) begin
                    line = rd(i_m + r);
                    py = (vy + r) % ROW_COUNT;
                    for (c = 0; c < 8; c++)
                        if (line[7-c]) begin
                            px = (vx + c) % SCREEN_WIDTH;
                            at = py * SCREEN_WIDTH + px;
                            if (fb_m[at]) hit = 1;
                            fb_m[at] = !fb_m[at];
                        end
                end
                v_m[VF_INDEX] = hit; drew = 1; pc = nxt;
            end
            OP_KEY:
                if (nn == KEY_SKP) pc = keys_m[vx[3:0]] ? skip : nxt;
                else if (nn == KEY_SKNP) pc = !keys_m[vx[3:0]] ? skip : nxt;
                else unk = 1;
            default:
            begin
                pc = nxt;
                case (nn)
                    FN_GETDT: v_m[x] = dt_m;
                    FN_WKEY:
                    begin
                        for (k = 0; k < KEY_COUNT; k++)
                            if (keys_m[k]) break;
                        if (k < KEY_COUNT) v_m[x] = k;
                        else begin wk = 1; pc = pc_m; end
                    end
                    FN_SETDT: dt_m = vx;
                    FN_SETST: st_m = vx;
                    FN_ADDI: i_m = i_m + vx;
                    FN_FONT: i_m = vx * 5;
                    FN_BCD:
                    begin
                        wr(i_m, vx / 100); wr(i_m + 1, (vx / 10) % 10); wr(i_m + 2, vx % 10);
                    end
                    FN_STORE: for (k = 0; k <= x; k++) wr(i_m + k, v_m[k]);
                    FN_LOAD: for (k = 0; k <= x; k++) v_m[k] = rd(i_m + k);
                    default: begin unk = 1; pc = pc_m; end
                endcase
            end
        endcase
        pc_m = pc;
        if (dt_m != 0) dt_m--;
        if (st_m != 0) st_m--;
    endtask

    initial
    begin
        foreach (mem_m[j]) mem_m[j] = 0;
        foreach (v_m[j]) v_m[j] = 0;
        foreach (stk_m[j]) stk_m[j] = 0;
        foreach (fb_m[j]) fb_m[j] = 0;
        foreach (keys_m[j]) keys_m[j] = 0;
        i_m = 0; pc_m = PC_RESET; sp_m = 0; dt_m = 0; st_m = 0;
        fail_count = 0; pending = 0;
    end

    always @(posedge clk)
    begin
        status_t s, e;
        if (rst_n && in_valid && in_ready) begin
            s = '0;
            case (req_type)
                REQ_CODE_LOAD: wr(address, load_byte);
                REQ_CODE_KEY: keys_m[key_index] = key_down;
                REQ_CODE_CYCLE: execute_instr(random_byte, s.drew, s.wait_key, s.unk);
                default: if (address < SCREEN_PIXELS) s.pix = fb_m[address];
            endcase
            s.pc = pc_m;
            s.snd = st_m != 0;
            expected_status.push_back(s);
        end
        if (rst_n && out_valid && out_ready) begin
            if (expected_status.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else begin
                e = expected_status.pop_front();
                if (pixel_value !== e.pix) begin
                    $error("pixel_value exp %0d got %0d", e.pix, pixel_value); fail_count++;
                end
                if (program_counter !== e.pc) begin
                    $error("program_counter exp %h got %h", e.pc, program_counter);
                    fail_count++;
                end
                if (drew_sprite !== e.drew) begin
                    $error("drew_sprite exp %0d got %0d", e.drew, drew_sprite); fail_count++;
                end
                if (sound_active !== e.snd) begin
                    $error("sound_active exp %0d got %0d", e.snd, sound_active); fail_count++;
                end
                if (waiting_for_key !== e.wait_key) begin
                    $error("waiting_for_key exp %0d got %0d", e.wait_key, waiting_for_key);
                    fail_count++;
                end
                if (unknown_opcode !== e.unk) begin
                    $error("unknown_opcode exp %0d got %0d", e.unk, unknown_opcode);
                    fail_count++;
                end
            end
        end
        pending = expected_status.size();
    end
endmodule

### tb/sv/tb_chip8_interpreter_core.sv
module tb_chip8_interpreter_core;
    import c8i_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [1:0]  req_type = REQ_CODE_LOAD;
    logic [11:0] address = 0;
    logic [7:0]  load_byte = 0;
    logic [3:0]  key_index = 0;
    logic        key_down = 0;
    logic [7:0]  random_byte = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic        pixel_value, drew_sprite, sound_active, waiting_for_key, unknown_opcode;
    logic [11:0] program_counter;
    int          fail_count, pending;
    bit          calm = 0;
    bit          hold_off = 0;

    always #5 clk = ~clk;

    chip8_interpreter_core dut (.*);
    chip8_core_checker checker_i (.*);

    // send one request, honouring the handshake; random gaps before it unless calm is set
    task automatic send_req(logic [1:0] rt, logic [11:0] a, logic [7:0] b, logic [3:0] ki,
                            logic kd, logic [7:0] rb);
        if (!calm)
            while ($urandom_range(99) < 37) @(posedge clk);
        in_valid <= 1; req_type <= rt; address <= a; load_byte <= b;
        key_index <= ki; key_down <= kd; random_byte <= rb;
        do @(posedge clk); while (!in_ready);
        in_valid <= 0;
    endtask

    task automatic load_op(logic [11:0] a, logic [15:0] op);
        send_req(REQ_CODE_LOAD, a, op[15:8], $urandom, $urandom, $urandom);
        send_req(REQ_CODE_LOAD, a + 12'd1, op[7:0], $urandom, $urandom, $urandom);
    endtask

    task automatic run_op(logic [15:0] op);
        load_op(program_counter_guess, op);
        send_req(REQ_CODE_CYCLE, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // PC tracking for placing opcodes: wait for results, then use output
    logic [11:0] program_counter_guess;
    logic [11:0] last_pc = PC_RESET;
    always @(posedge clk)
        if (out_valid && out_ready) last_pc <= program_counter;

    task automatic sync_pc();
        while (pending != 0) @(posedge clk);
        program_counter_guess = last_pc;
    endtask

    function automatic logic [15:0] rand_op();
        logic [15:0] op;
        op = $urandom;
        case ($urandom_range(9))
            0: op[7:0] = {4'h0, $urandom_range(3) == 0 ? 4'h0 : op[3:0]};
            1: op = {OP_ALU, op[11:4], 4'($urandom_range(8) == 8 ? 14 : $urandom_range(7))};
            2: op = {OP_MISC, op[11:8], 8'(FN_STORE)};
            3: op = {OP_MISC, op[11:8], 8'(FN_LOAD)};
            4: op = {OP_DRW, op[11:4], 4'($urandom_range(4))};
            5: op = {OP_KEY, op[11:8], $urandom_range(1) ? KEY_SKP : KEY_SKNP};
            6: op = {OP_MISC, op[11:8], 8'(FN_BCD)};
            default: ;
        endcase
        return op;
    endfunction

    initial
    begin
        int hold;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        program_counter_guess = PC_RESET;
        // directed: arithmetic and flags, draw, key wait, pixel reads, call, return and clear
        run_op(16'h60FF); sync_pc();
        run_op(16'h6101); sync_pc();
        run_op(16'h8014); sync_pc();
        run_op(16'h6F80); sync_pc();
        run_op(16'h8FFE); sync_pc();
        run_op(16'h8105); sync_pc();
        run_op(16'h8017); sync_pc();
        run_op(16'h8016); sync_pc();
        run_op(16'h80F8); sync_pc();
        run_op(16'hF018); sync_pc();
        run_op(16'hF0FF); sync_pc();
        run_op(16'hA7FE); sync_pc();
        run_op(16'hD3FF); sync_pc();
        run_op(16'hD000); sync_pc();
        run_op(16'hF30A); sync_pc();
        send_req(REQ_CODE_KEY, 0, 0, 4'hF, 1, 0);
        run_op(16'hF30A); sync_pc();
        send_req(REQ_CODE_PIXEL, 12'hFFF, 0, 0, 0, 0);
        send_req(REQ_CODE_PIXEL, 12'd0, 0, 0, 0, 0);
        run_op(16'h2FFE); sync_pc();
        run_op(16'h00EE); sync_pc();
        run_op(16'h00E0); sync_pc();
        // random programs of opcodes, mixed with keys, loads, pixel reads and bare cycle requests
        for (int i = 0; i < 500; i++) begin
            if (i == 200) calm = 1;
            if (i == 280) calm = 0;
            if (i == 350) hold_off = 1;
            case ($urandom_range(9))
                0: send_req(REQ_CODE_KEY, $urandom, $urandom, $urandom, $urandom, $urandom);
                1: send_req(REQ_CODE_PIXEL, $urandom, $urandom, $urandom, $urandom, $urandom);
                2: send_req(REQ_CODE_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom);
                3: send_req(REQ_CODE_CYCLE, $urandom, $urandom, $urandom, $urandom, $urandom);
                default:
                begin
                    sync_pc();
                    run_op(rand_op());
                end
            endcase
        end
        hold = 0;
        while (pending != 0 && hold < 100000) begin
            @(posedge clk);
            hold++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("chip8_interpreter_core regression: pass");
        else
            $display("chip8_interpreter_core regression: fail");
        $finish;
    end

    // receiver: random stalls, calm stretch, one long hold-off
    initial
    begin
        forever begin
            @(posedge clk);
            if (hold_off) begin
                out_ready <= 0;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            out_ready <= calm || ($urandom_range(99) >= 37);
        end
    end

    initial
    begin
        #20ms;
        $display("chip8_interpreter_core regression: fail");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl/core
rtl/core/c8i_pkg.sv
rtl/core/c8i_front.sv
rtl/core/c8i_back.sv
rtl/core/chip8_interpreter_core.sv
tb/sv/chip8_core_checker.sv
tb/sv/tb_chip8_interpreter_core.sv
